[hw/rtl/cfr_pkg.sv]
package cfr_pkg;

    localparam int CFR_MAX_FRAME_BYTES = 256;

    // configuration register indexes
    localparam logic [1:0] REG_STATION_ID = 2'd0;

    // header
    localparam logic [7:0] HEADER_BYTE    = 8'hFF;
    localparam logic [2:0] HEADER_FF_COUNT = 3'd5;
    localparam logic [7:0] BROADCAST_ADDR = 8'h00;

    // frame byte positions
    localparam int IDX_CMD    = 6;
    localparam int IDX_LEN_LO = 7;
    localparam int IDX_LEN_HI = 8;

    // command codes
    localparam logic [7:0] CMD_READ_A  = 8'h14;
    localparam logic [7:0] CMD_READ_B  = 8'h15;
    localparam logic [7:0] CMD_WRITE   = 8'h17;
    localparam logic [7:0] CMD_READ_C  = 8'h19;
    localparam logic [7:0] CMD_EXT     = 8'h20;
    localparam logic [7:0] CMD_CONTROL = 8'h21;

    // frame lengths
    localparam int LEN_SHORT    = 9;
    localparam int LEN_LONG     = 15;
    localparam int LEN_CONTROL  = 11;
    localparam int LEN_EXT_BASE = 11;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_end;
        logic       crc_ok;
        logic       station_match;
    } cfr_result_t;

    // one byte through the reflected CRC-16/MODBUS register
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_header_seed();
        logic [15:0] c;
        c = CRC_INIT;
        for (int k = 0; k < 5; k++) begin
            c = crc_feed(c, HEADER_BYTE);
        end
        return c;
    endfunction

    // CRC after the five 0xFF preamble bytes
    localparam logic [15:0] CRC_HEADER_SEED = crc_header_seed();

endpackage

[hw/rtl/cfr_apb_regs.sv]
module cfr_apb_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  station_id
);

    logic [7:0] station_id_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_id_reg <= 8'h00;
        end else if (wr_en && paddr[3:2] == cfr_pkg::REG_STATION_ID) begin
            station_id_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'h0;
        if (paddr[3:2] == cfr_pkg::REG_STATION_ID) begin
            prdata = {24'h0, station_id_reg};
        end
    end

    assign station_id = station_id_reg;

endmodule

[hw/rtl/cfr_frame_ctrl.sv]
module cfr_frame_ctrl #(
    parameter int MAX_FRAME_BYTES = cfr_pkg::CFR_MAX_FRAME_BYTES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          station_id,
    output cfr_pkg::cfr_result_t result
);

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = LEN_W + 1;

    logic [2:0]       run_reg, run_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       len_low_reg, len_low_next;
    logic [LEN_W-1:0] decl_reg, decl_next;
    logic [15:0]      crc_reg, crc_next;

    logic             hunting;
    logic [15:0]      crc_step;
    logic [8:0]       total_ext;
    logic [LEN_W-1:0] decl_v;
    logic [CMP_W-1:0] idx_p1, idx_p2, decl_c;
    logic             drop, last, clear;
    cfr_pkg::cfr_result_t res;

    assign hunting   = (idx_reg == '0);
    assign crc_step  = cfr_pkg::crc_feed(crc_reg, rx_byte);
    assign total_ext = 9'(cfr_pkg::LEN_EXT_BASE) + {1'b0, len_low_reg};
    assign idx_p1    = CMP_W'(idx_reg) + CMP_W'(1);
    assign idx_p2    = CMP_W'(idx_reg) + CMP_W'(2);
    assign decl_c    = CMP_W'(decl_v);

    always_comb begin
        run_next     = run_reg;
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        len_low_next = len_low_reg;
        decl_next    = decl_reg;
        crc_next     = crc_reg;
        decl_v       = decl_reg;
        drop         = 1'b0;
        last         = 1'b0;
        clear        = 1'b0;
        res               = '0;
        res.data_byte     = rx_byte;
        res.byte_index    = 8'(idx_reg);

        if (step) begin
            if (hunting) begin
                if (run_reg == cfr_pkg::HEADER_FF_COUNT &&
                    (rx_byte == station_id || rx_byte == cfr_pkg::BROADCAST_ADDR)) begin
                    addr_next = rx_byte;
                    crc_next  = cfr_pkg::crc_feed(cfr_pkg::CRC_HEADER_SEED, rx_byte);
                    idx_next  = IDX_W'(cfr_pkg::IDX_CMD);
                end else if (rx_byte == cfr_pkg::HEADER_BYTE) begin
                    // saturate: only the last five bytes matter
                    if (run_reg != cfr_pkg::HEADER_FF_COUNT) begin
                        run_next = run_reg + 3'd1;
                    end
                end else begin
                    run_next = '0;
                end
            end else begin
                if (idx_reg == IDX_W'(cfr_pkg::IDX_CMD)) begin
                    cmd_next = rx_byte;
                    case (rx_byte)
                        cfr_pkg::CMD_READ_A,
                        cfr_pkg::CMD_READ_B,
                        cfr_pkg::CMD_READ_C:  decl_v = LEN_W'(cfr_pkg::LEN_SHORT);
                        cfr_pkg::CMD_WRITE:   decl_v = LEN_W'(cfr_pkg::LEN_LONG);
                        cfr_pkg::CMD_CONTROL: decl_v = LEN_W'(cfr_pkg::LEN_CONTROL);
                        cfr_pkg::CMD_EXT:     decl_v = '0;
                        default:              drop   = 1'b1;
                    endcase
                end else if (cmd_reg == cfr_pkg::CMD_EXT &&
                             idx_reg == IDX_W'(cfr_pkg::IDX_LEN_LO)) begin
                    len_low_next = rx_byte;
                end else if (cmd_reg == cfr_pkg::CMD_EXT &&
                             idx_reg == IDX_W'(cfr_pkg::IDX_LEN_HI)) begin
                    // any nonzero high byte already overflows the buffer
                    if (rx_byte != 8'h00 || total_ext > 9'(MAX_FRAME_BYTES)) begin
                        drop = 1'b1;
                    end else begin
                        decl_v = LEN_W'(total_ext);
                    end
                end

                // the two trailing bytes are the received CRC, low byte first
                if (decl_v == '0 || idx_p2 < decl_c) begin
                    crc_next = crc_step;
                end else if (idx_p2 == decl_c) begin
                    len_low_next = rx_byte;
                end

                last      = (decl_v != '0) && (idx_p1 == decl_c);
                decl_next = decl_v;

                if (drop) begin
                    clear = 1'b1;
                end else begin
                    res.valid     = 1'b1;
                    res.frame_end = last;
                    if (last) begin
                        res.crc_ok        = ({rx_byte, len_low_reg} == crc_reg);
                        res.station_match = (addr_reg == station_id);
                        clear             = 1'b1;
                    end else begin
                        idx_next = IDX_W'(idx_p1);
                    end
                end
            end
        end

        if (clear) begin
            run_next     = '0;
            idx_next     = '0;
            cmd_next     = 8'h00;
            addr_next    = 8'h00;
            len_low_next = 8'h00;
            decl_next    = '0;
            crc_next     = cfr_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            idx_reg     <= '0;
            cmd_reg     <= 8'h00;
            addr_reg    <= 8'h00;
            len_low_reg <= 8'h00;
            decl_reg    <= '0;
            crc_reg     <= cfr_pkg::CRC_INIT;
        end else begin
            run_reg     <= run_next;
            idx_reg     <= idx_next;
            cmd_reg     <= cmd_next;
            addr_reg    <= addr_next;
            len_low_reg <= len_low_next;
            decl_reg    <= decl_next;
            crc_reg     <= crc_next;
        end
    end

    assign result = res;

    a_no_partial_header: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg == '0 || idx_reg >= IDX_W'(cfr_pkg::IDX_CMD))
        else $error("byte counter inside header range");

    a_hunt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        hunting |-> (crc_reg == cfr_pkg::CRC_INIT && decl_reg == '0))
        else $error("frame state not cleared while hunting");

    a_end_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.valid && res.frame_end) |=> hunting)
        else $error("receiver did not resync after frame end");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= cfr_pkg::HEADER_FF_COUNT)
        else $error("preamble run counter overflow");

    a_index_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        decl_reg != '0 |-> CMP_W'(idx_reg) < CMP_W'(decl_reg))
        else $error("byte index beyond declared frame length");

endmodule

[hw/rtl/command_frame_receiver_crc16.sv]
// A byte accepted on s_ is held in the input register, decoded, and shown on m_ from the output register.
// Throughput: one byte per cycle while m_ready holds; header and dropped bytes produce no output beat.
// The per-byte CRC step and frame decode sit between the input and output registers.
// Reset (aresetn low, synchronous): station_id to 0, receiver back to hunting,
// CRC to 0xFFFF, both pipeline registers empty.
module command_frame_receiver_crc16 #(
    parameter int MAX_FRAME_BYTES = cfr_pkg::CFR_MAX_FRAME_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_byte_index,
    output logic        m_frame_end,
    output logic        m_crc_ok,
    output logic        m_station_match
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    cfr_pkg::cfr_result_t out_reg;
    logic                 fire;
    logic [7:0]           station_id;
    cfr_pkg::cfr_result_t result;

    cfr_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .station_id (station_id)
    );

    cfr_frame_ctrl #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (fire),
        .rx_byte    (in_byte_reg),
        .station_id (station_id),
        .result     (result)
    );

    // advance the held byte whenever the output slot is free or draining
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= result.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && result.valid) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_data_byte     = out_reg.data_byte;
    assign m_byte_index    = out_reg.byte_index;
    assign m_frame_end     = out_reg.frame_end;
    assign m_crc_ok        = out_reg.crc_ok;
    assign m_station_match = out_reg.station_match;

endmodule
